>>> rtl/ctl_pkg.sv
// shared widths, register indexes and direction tables for the contour trace unit
package ctl_pkg;

  // item and register widths
  localparam int COORD_W = 8;
  localparam int PIX_W   = 8;
  localparam int DIM_W   = 9;
  localparam int LEN_W   = 18;
  localparam int ADDR_W  = 2 * COORD_W;
  localparam int FRAME_DEPTH = 1 << ADDR_W;

  // largest usable image dimension
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(1 << COORD_W);

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_STEP_LIMIT   = 2'd2;

  // item operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TRACE = 1'b1;

  // column offset of a ring direction, two-bit signed
  function automatic logic [1:0] dx_of(input logic [3:0] idx);
    logic [1:0] r;
    case (idx[2:0])
      3'd0: r = 2'b11;
      3'd1: r = 2'b00;
      3'd2: r = 2'b01;
      3'd3: r = 2'b01;
      3'd4: r = 2'b01;
      3'd5: r = 2'b00;
      3'd6: r = 2'b11;
      3'd7: r = 2'b11;
      default: r = 2'b00;
    endcase
    return r;
  endfunction

  // row offset of a ring direction, two-bit signed
  function automatic logic [1:0] dy_of(input logic [3:0] idx);
    logic [1:0] r;
    case (idx[2:0])
      3'd0: r = 2'b11;
      3'd1: r = 2'b11;
      3'd2: r = 2'b11;
      3'd3: r = 2'b00;
      3'd4: r = 2'b01;
      3'd5: r = 2'b01;
      3'd6: r = 2'b01;
      3'd7: r = 2'b00;
      default: r = 2'b00;
    endcase
    return r;
  endfunction

  // search restart point after stepping in a direction
  function automatic logic [3:0] restart_of(input logic [3:0] idx);
    return 4'((idx[2:0] + 3'd6) & 3'd7);
  endfunction

endpackage

>>> rtl/contour_trace_length_unit.sv
// top level: frame store loader and moore-neighbour boundary length tracer
//
// Items arrive on the in_ ports and are taken at a rising edge with start high
// and busy low. A write item (in_op low) stores one pixel in a 256 x 256 frame
// store in that cycle and gives no result; busy stays low, so writes stream at
// one per cycle. A trace item names the top-most, left-most pixel of a region;
// it gives exactly one result on out_boundary_length / out_limit_reached,
// marked by out_valid for one cycle. The receiver cannot hold results off.
// A single-pixel trace gives its result in the next cycle with busy low.
// Any other trace keeps busy high: the tracer first fetches the start value,
// then each boundary step scans the neighbour ring from its restart direction,
// testing a neighbour outside the image by its bounds alone and reading one
// inside it from the frame store (which has one read port with registered
// data); out_valid rises in the first cycle with busy low again.
// The step_limit register ends walks that never return to the start.
// Registers sit on the APB port at byte addresses 0 (width), 4 (height) and
// 8 (step limit); write them only while the block is idle.
// Reset clears the sequencer and restores the register defaults; the frame
// store is not cleared and must be written before it is traced.
module contour_trace_length_unit import ctl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // item channel
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [COORD_W-1:0] in_pos_x,
  input  logic [COORD_W-1:0] in_pos_y,
  input  logic [PIX_W-1:0]   in_pixel_value,
  input  logic               in_single_pixel_region,
  // result channel
  output logic               out_valid,
  output logic [LEN_W-1:0]   out_boundary_length,
  output logic               out_limit_reached,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TGT  = 4'b0010,
    S_SCAN = 4'b0100,
    S_CMP  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [DIM_W-1:0]   width_r, height_r;
  logic [LEN_W-1:0]   limit_r;
  logic [COORD_W-1:0] x_r, x_nxt, y_r, y_nxt, sx_r, sx_nxt, sy_r, sy_nxt;
  logic [PIX_W-1:0]   tgt_r, tgt_nxt;
  logic [3:0]         dir_r, dir_nxt;
  logic [2:0]         k_r, k_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]   out_len_r, out_len_nxt;
  logic               out_flag_r, out_flag_nxt;

  logic               accept, cfg_wr;
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [LEN_W-1:0]   lim_eff;
  logic [3:0]         idx;
  logic [1:0]         dx, dy;
  logic [DIM_W:0]     nx, ny;
  logic               nb_in;
  logic               nb_home;
  logic [ADDR_W-1:0]  rd_addr;
  logic [PIX_W-1:0]   rd_data;

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign busy   = (state_r != S_IDLE);

  // frame store
  ctl_frame_ram u_ram (
    .clk     (clk),
    .wr_en   (accept && (in_op == OP_WRITE)),
    .wr_addr ({in_pos_y, in_pos_x}),
    .wr_data (in_pixel_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // effective image size and limit
  assign w_eff   = (width_r > DIM_MAX) ? DIM_MAX : width_r;
  assign h_eff   = (height_r > DIM_MAX) ? DIM_MAX : height_r;
  assign lim_eff = (limit_r == '0) ? LEN_W'(1) : limit_r;

  // shared neighbour unit: position and bounds of the ring entry under test
  assign idx     = dir_r + {1'b0, k_r};
  assign dx      = dx_of(idx);
  assign dy      = dy_of(idx);
  assign nx      = {2'b00, x_r} + {{(DIM_W-1){dx[1]}}, dx};
  assign ny      = {2'b00, y_r} + {{(DIM_W-1){dy[1]}}, dy};
  assign nb_in   = !nx[DIM_W] && (nx[DIM_W-1:0] < w_eff) &&
                   !ny[DIM_W] && (ny[DIM_W-1:0] < h_eff);
  assign nb_home = (nx[COORD_W-1:0] == sx_r) && (ny[COORD_W-1:0] == sy_r);

  // read address: start pixel while idle, else the neighbour under test
  assign rd_addr = (state_r == S_IDLE) ? {in_pos_y, in_pos_x}
                                       : {ny[COORD_W-1:0], nx[COORD_W-1:0]};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    tgt_nxt       = tgt_r;
    dir_nxt       = dir_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_len_nxt   = out_len_r;
    out_flag_nxt  = out_flag_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_op == OP_TRACE)) begin
          if (in_single_pixel_region) begin
            out_valid_nxt = 1'b1;
            out_len_nxt   = LEN_W'(1);
            out_flag_nxt  = 1'b0;
          end else begin
            x_nxt     = in_pos_x;
            y_nxt     = in_pos_y;
            sx_nxt    = in_pos_x;
            sy_nxt    = in_pos_y;
            dir_nxt   = 4'd1;
            k_nxt     = 3'd0;
            cnt_nxt   = LEN_W'(1);
            state_nxt = S_TGT;
          end
        end
      end
      S_TGT: begin
        tgt_nxt   = rd_data;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (nb_in) begin
          state_nxt = S_CMP;
        end else if (k_r == 3'd7) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = cnt_r;
          out_flag_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      S_CMP: begin
        if (rd_data == tgt_r) begin
          x_nxt   = nx[COORD_W-1:0];
          y_nxt   = ny[COORD_W-1:0];
          dir_nxt = restart_of(idx);
          k_nxt   = 3'd0;
          if (nb_home) begin
            out_valid_nxt = 1'b1;
            out_len_nxt   = cnt_r;
            out_flag_nxt  = 1'b0;
            state_nxt     = S_IDLE;
          end else if (cnt_r >= lim_eff) begin
            out_valid_nxt = 1'b1;
            out_len_nxt   = cnt_r;
            out_flag_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + LEN_W'(1);
            state_nxt = S_SCAN;
          end
        end else if (k_r == 3'd7) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = cnt_r;
          out_flag_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      width_r     <= DIM_MAX;
      height_r    <= DIM_MAX;
      limit_r     <= '1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_IMAGE_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
          REG_IMAGE_HEIGHT: height_r <= pwdata[DIM_W-1:0];
          REG_STEP_LIMIT:   limit_r  <= pwdata[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    tgt_r     <= tgt_nxt;
    dir_r     <= dir_nxt;
    k_r       <= k_nxt;
    cnt_r     <= cnt_nxt;
    out_len_r <= out_len_nxt;
    out_flag_r <= out_flag_nxt;
  end

  // register read-back
  always_comb begin
    case (paddr[3:2])
      REG_IMAGE_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, width_r};
      REG_IMAGE_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, height_r};
      REG_STEP_LIMIT:   prdata = {{(32-LEN_W){1'b0}}, limit_r};
      default:          prdata = '0;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_boundary_length = out_len_r;
  assign out_limit_reached   = out_flag_r;

  // every trace counts at least the start pixel
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_len_r != '0))
    else $error("result with zero boundary length");

  // the walk ends only by giving its result
  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("trace ended without a result");

  // a result is only shown while the sequencer is idle
  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result while tracing");

  // a compare always follows a neighbour read
  a_cmp_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ($past(state_r) == S_SCAN))
    else $error("compare without a neighbour read");

endmodule

>>> rtl/ctl_frame_ram.sv
// frame store: one write port, one registered read port
module ctl_frame_ram import ctl_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [PIX_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [PIX_W-1:0]  rd_data
);

  logic [PIX_W-1:0] mem [0:FRAME_DEPTH-1];

  // pixel write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
